### hdl/snfs_pkg.sv
// Shared types and constants for the sparse neighbour feature sum block.
package snfs_pkg;

    localparam int OP_W      = 2;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 7;
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 32;
    localparam int ACC_W     = SUM_W + 1;   // saturation mark on top of the sum

    localparam int S_TDATA_W = 48;          // row, neighbor, feature, value, zero fill
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = SUM_W;
    localparam int M_TUSER_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

### hdl/sparse_neighbor_feature_sum_top.sv
// Top level: feature store, saturating accumulator store and the sequencer that works them.
//
//  channel  | dir | transaction                      | fields (low bit up)
//  ---------+-----+----------------------------------+------------------------------------
//  s_axis   | in  | load / edge / read command       | tuser: op; tdata: row, neighbor,
//           |     |                                  |   feature, value
//  m_axis   | out | accumulator element (reads only) | tdata: sum; tuser: saturated
//
// A read may also wait on m_axis. A new transaction is taken only once the sequencer is back
// in idle. An edge streams one feature a cycle through the single adder and saturate stage,
// set by the one read and one write port of the store. After reset the accumulator store is
// swept clear, one entry a cycle, all NODES*FEATURES entries (131072 with the defaults) with
// s_axis_tready low. A stalled result sits in the output register; a following read waits for
// it, loads and edges go ahead.
module sparse_neighbor_feature_sum_top
    import snfs_pkg::*;
#(
    parameter int NODES    = 1024,
    parameter int FEATURES = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row[9:0], neighbor[19:10], feature[26:20],
                                                // value[42:27], zeros[47:43]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // op[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // sum[31:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser   // saturated[0]
);

    localparam int DEPTH = NODES * FEATURES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_EDGE_RUN,
        ST_EDGE_DRAIN,
        ST_RD_WAIT,
        ST_RD_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ROW_W-1:0]       nb_reg, nb_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [AW-1:0]          daddr_reg, daddr_next;
    logic [AW-1:0]          saddr_reg, saddr_next;
    logic [AW-1:0]          waddr_reg, waddr_next;
    logic                   wvalid_reg, wvalid_next;
    logic [FW-1:0]          k_reg, k_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]       m_sum_reg, m_sum_next;
    logic                   m_sat_reg, m_sat_next;

    logic [ACC_W-1:0]       acc_mem [DEPTH];
    logic [VALUE_W-1:0]     feat_mem [DEPTH];
    logic [ACC_W-1:0]       acc_q;
    logic [VALUE_W-1:0]     feat_q;

    logic                   acc_we;
    logic [AW-1:0]          acc_waddr;
    logic [ACC_W-1:0]       acc_wdata;
    logic                   feat_we;
    logic [AW-1:0]          feat_waddr;

    logic                   in_accept;
    logic                   row_ok, nb_ok, col_ok;
    logic [AW-1:0]          row_base, nb_base, cell_addr;
    logic [SUM_W:0]         add_full;
    logic [ACC_W-1:0]       add_word;
    logic                   out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign row_ok    = 32'(row_reg) < NODES;
    assign nb_ok     = 32'(nb_reg) < NODES;
    assign col_ok    = 32'(col_reg) < FEATURES;
    assign row_base  = AW'(32'(row_reg) * FEATURES);
    assign nb_base   = AW'(32'(nb_reg) * FEATURES);
    assign cell_addr = AW'(32'(row_reg) * FEATURES + 32'(col_reg));

    // one adder, saturating; the mark is sticky
    assign add_full  = {1'b0, acc_q[SUM_W-1:0]} + (SUM_W+1)'(feat_q);
    assign add_word  = add_full[SUM_W] ? {1'b1, SUM_MAX} : {acc_q[SUM_W], add_full[SUM_W-1:0]};

    assign acc_we    = (state_reg == ST_CLEAR) || wvalid_reg;
    assign acc_waddr = (state_reg == ST_CLEAR) ? clr_reg : waddr_reg;
    assign acc_wdata = (state_reg == ST_CLEAR) ? '0 : add_word;

    assign feat_we    = (state_reg == ST_SETUP) && (op_reg == OP_LOAD) && row_ok && col_ok;
    assign feat_waddr = cell_addr;

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_q <= acc_mem[daddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (feat_we) begin
            feat_mem[feat_waddr] <= value_reg;
        end
        feat_q <= feat_mem[saddr_reg];
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        row_next     = row_reg;
        nb_next      = nb_reg;
        col_next     = col_reg;
        value_next   = value_reg;
        clr_next     = clr_reg;
        daddr_next   = daddr_reg;
        saddr_next   = saddr_reg;
        waddr_next   = waddr_reg;
        wvalid_next  = 1'b0;
        k_next       = k_reg;
        rd_ok_next   = rd_ok_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_sum_next   = m_sum_reg;
        m_sat_next   = m_sat_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    op_next    = s_axis_tuser[OP_W-1:0];
                    row_next   = s_axis_tdata[9:0];
                    nb_next    = s_axis_tdata[19:10];
                    col_next   = s_axis_tdata[26:20];
                    value_next = s_axis_tdata[42:27];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_IDLE;
                case (op_reg)
                    OP_EDGE: begin
                        if (row_ok && nb_ok) begin
                            daddr_next = row_base;
                            saddr_next = nb_base;
                            k_next     = '0;
                            state_next = ST_EDGE_RUN;
                        end
                    end
                    OP_READ: begin
                        daddr_next = cell_addr;
                        rd_ok_next = row_ok && col_ok;
                        state_next = ST_RD_WAIT;
                    end
                    default: begin
                        // load is written by feat_we this cycle; unknown op does nothing
                    end
                endcase
            end
            ST_EDGE_RUN: begin
                // read feature k while the sum for k-1 is written back
                wvalid_next = 1'b1;
                waddr_next  = daddr_reg;
                daddr_next  = daddr_reg + 1'b1;
                saddr_next  = saddr_reg + 1'b1;
                k_next      = k_reg + 1'b1;
                if (k_reg == FW'(FEATURES - 1)) begin
                    state_next = ST_EDGE_DRAIN;
                end
            end
            ST_EDGE_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_RD_WAIT: begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                // daddr_reg is held, so acc_q stays valid while the output is busy
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = rd_ok_reg ? acc_q[SUM_W-1:0] : '0;
                    m_sat_next   = rd_ok_reg && acc_q[SUM_W];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wvalid_reg  <= wvalid_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg    <= op_next;
        row_reg   <= row_next;
        nb_reg    <= nb_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        daddr_reg <= daddr_next;
        saddr_reg <= saddr_next;
        waddr_reg <= waddr_next;
        k_reg     <= k_next;
        rd_ok_reg <= rd_ok_next;
        m_sum_reg <= m_sum_next;
        m_sat_reg <= m_sat_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_sum_reg;
    assign m_axis_tuser  = m_sat_reg;

endmodule

### hdl/snfs_checker.sv
// Port-level checks for the sparse neighbour feature sum top level, with its bind.
module snfs_checker
    import snfs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // a stalled result transaction stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // a saturated element always reads back at full scale
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == SUM_MAX)
        else $error("saturation mark without a full-scale sum");

    // every command is decoded before the next one is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while the previous one is in setup");

endmodule

bind sparse_neighbor_feature_sum_top snfs_checker u_snfs_checker (.*);
